>>> rtl/frci_pkg.sv
// Package of the feed-rate colormap interpolator: control point layout,
// register indexes, reset values and the sequencer state type. No dependencies.
package frci_pkg;

  localparam int MAX_POINTS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 15;

  localparam int POS_BITS      = 16;
  localparam int POS_ONE       = 32768;
  localparam int POS_DIV_STEPS = 15;
  localparam int COLOR_BITS    = 8;
  localparam int NUM_COMPS     = 4;
  localparam int SEG_BITS      = 4;
  localparam int SLOT_BITS     = 4;

  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;
  localparam int NUM_POINTS_BITS = 5;

  localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_POINTS      = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FEED_FULL_SCALE = 4'd1;

  localparam logic [NUM_POINTS_BITS-1:0] NUM_POINTS_RESET      = 5'd0;
  localparam logic [POS_BITS-1:0]        FEED_FULL_SCALE_RESET = 16'd6000;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // One control point: position and red, green, blue, alpha (red in col[0]).
  typedef struct packed {
    logic [NUM_COMPS-1:0][COLOR_BITS-1:0] col;
    logic [POS_BITS-1:0]                  pos;
  } point_t;

  localparam int POINT_BITS = $bits(point_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIVP,
    S_SRD,
    S_SCMP,
    S_LRD,
    S_LCAP,
    S_DIVF,
    S_MUL,
    S_ACC,
    S_OUT
  } state_t;

endpackage

>>> rtl/frci_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module frci_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/frci_div_step.sv
// One step of restoring division, shared by the position and fraction divides.
// Depends on frci_pkg.
module frci_div_step (
  input  logic [frci_pkg::POS_BITS-1:0] rem,
  input  logic [frci_pkg::POS_BITS-1:0] den,
  output logic [frci_pkg::POS_BITS-1:0] rem_next,
  output logic                          qbit
);
  import frci_pkg::*;

  logic [POS_BITS:0] shifted;

  // The remainder stays below the divisor, so the result fits again.
  always_comb begin
    shifted  = {rem, 1'b0};
    qbit     = shifted >= {1'b0, den};
    rem_next = qbit ? POS_BITS'(shifted - {1'b0, den}) : POS_BITS'(shifted);
  end

endmodule

>>> rtl/frci_lerp.sv
// Linear interpolation of one 8-bit color component, with a registered product.
// Depends on frci_pkg.
module frci_lerp #(
  parameter int FRACTION_BITS = frci_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic [FRACTION_BITS:0]            frac,
  input  logic [frci_pkg::COLOR_BITS-1:0]   c0,
  input  logic [frci_pkg::COLOR_BITS-1:0]   c1,
  output logic [frci_pkg::COLOR_BITS-1:0]   color
);
  import frci_pkg::*;

  localparam int PW = FRACTION_BITS + 11;

  logic signed [COLOR_BITS:0] diff;
  logic signed [PW-1:0]       prod;
  logic [COLOR_BITS-1:0]      base;
  logic signed [PW-1:0]       base_ext;
  logic signed [PW-1:0]       half;
  logic signed [PW-1:0]       sum;

  assign diff = $signed({1'b0, c1}) - $signed({1'b0, c0});

  always_ff @(posedge clk) begin
    prod <= PW'($signed({1'b0, frac}) * diff);
    base <= c0;
  end

  // (1 - d) * c0 + d * c1 is written as c0 + d * (c1 - c0), rounded half up.
  always_comb begin
    base_ext = $signed(PW'({base, {FRACTION_BITS{1'b0}}}));
    half     = $signed(PW'(1) << (FRACTION_BITS - 1));
    sum      = base_ext + prod + half;
    color    = sum[FRACTION_BITS +: COLOR_BITS];
  end

endmodule

>>> rtl/feed_rate_colormap_interpolator.sv
// Feed-rate colormap interpolator: top level with the sequencer and the registers.
// Depends on frci_pkg, frci_ram, frci_div_step and frci_lerp.
//
// Write words (tuser 0) load a control point. A lookup word (tuser 1) runs
// shared divider steps to scale the feed rate (none when it reaches full
// scale), then a read and a compare for each point visited by the upward
// segment search through the one read port of the point memory, a read of
// the lower point, divider steps for the fraction (none when it clamps to 0
// or 1), a multiply and an add for each of the four components and a handover
// of the result. When fewer than two points are in use, a lookup goes
// straight to the handover. The result word is offered in the same cycle in
// which the block is ready again. The handover waits while an earlier result
// word is still unaccepted. The block takes no new word while a lookup is
// running.
module feed_rate_colormap_interpolator #(
  parameter int MAX_POINTS    = frci_pkg::MAX_POINTS_DEF,
  parameter int FRACTION_BITS = frci_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: point_index[3:0], point_pos[19:4], point_red[27:20],
  // point_green[35:28], point_blue[43:36], point_alpha[51:44],
  // feed_rate[67:52], zeros[71:68]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,
  // s_tuser: req_type[0]
  input  logic        s_tuser,
  // m_tdata: red[7:0], green[15:8], blue[23:16], alpha[31:24], segment[35:32],
  // zeros[39:36]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  // m_tuser: no_map[0]
  output logic        m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [frci_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [frci_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import frci_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int QW = (FRACTION_BITS > POS_DIV_STEPS) ? FRACTION_BITS : POS_DIV_STEPS;
  localparam int CW = $clog2(QW + 1);

  // Input fields.
  logic                  req_type;
  logic [SLOT_BITS-1:0]  point_index;
  logic [POS_BITS-1:0]   point_pos;
  logic [COLOR_BITS-1:0] point_red, point_green, point_blue, point_alpha;
  logic [POS_BITS-1:0]   feed_rate;

  assign req_type    = s_tuser;
  assign point_index = s_tdata[3:0];
  assign point_pos   = s_tdata[19:4];
  assign point_red   = s_tdata[27:20];
  assign point_green = s_tdata[35:28];
  assign point_blue  = s_tdata[43:36];
  assign point_alpha = s_tdata[51:44];
  assign feed_rate   = s_tdata[67:52];

  // Registers.
  state_t                state, state_next;
  logic [NUM_POINTS_BITS-1:0] num_points;
  logic [POS_BITS-1:0]   feed_full_scale;
  logic [AW-1:0]         idx;
  logic [POS_BITS-1:0]   pos;
  logic [POS_BITS-1:0]   rem;
  logic [POS_BITS-1:0]   den;
  logic [QW-1:0]         quo;
  logic [CW-1:0]         cnt;
  logic [FRACTION_BITS:0] frac;
  logic [POS_BITS-1:0]   p1;
  logic [NUM_COMPS-1:0][COLOR_BITS-1:0] c0, c1, res_col, out_col;
  logic [1:0]            k;
  logic                  res_nomap, out_nomap;
  logic [SEG_BITS-1:0]   out_seg;

  // Combinational signals.
  logic                  in_fire, lookup_fire, write_fire;
  logic [NW-1:0]         n_eff;
  logic                  few_points;
  logic                  pos_sat;
  logic [AW-1:0]         last_seg;
  logic [AW-1:0]         idx_up;
  logic [AW-1:0]         rd_addr;
  logic                  ram_we;
  logic [AW-1:0]         wr_addr;
  point_t                wr_point;
  point_t                rd_point;
  logic [POS_BITS-1:0]   rem_next;
  logic                  qbit;
  logic                  frac_zero;
  logic [POS_BITS-1:0]   num_f, den_f;
  logic                  frac_full;
  logic                  search_more;
  logic [COLOR_BITS-1:0] lerp_color;
  logic                  out_free;

  assign cfg_ready   = 1'b1;
  assign in_fire     = s_tvalid && s_tready;
  assign lookup_fire = in_fire && (req_type == REQ_LOOKUP);
  assign write_fire  = in_fire && (req_type == REQ_WRITE);
  assign out_free    = !m_tvalid || m_tready;

  always_comb begin
    n_eff      = (32'(num_points) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(num_points);
    few_points = n_eff < NW'(2);
    last_seg   = AW'(n_eff - NW'(2));
    idx_up     = idx + AW'(1);
    // A feed at or above full scale (or a zero full scale) is position 1.0.
    pos_sat    = feed_rate >= feed_full_scale;
    // The search stops at a point above the position or at the last segment.
    search_more = (rd_point.pos <= pos) && (idx != last_seg);
    frac_zero  = !((p1 > rd_point.pos) && (pos > rd_point.pos));
    num_f      = pos - rd_point.pos;
    den_f      = p1 - rd_point.pos;
    frac_full  = num_f >= den_f;
  end

  // Point memory write path; out-of-range slots are dropped.
  always_comb begin
    ram_we         = write_fire && (32'(point_index) < MAX_POINTS);
    wr_addr        = AW'(point_index);
    wr_point.pos   = (point_pos > POS_BITS'(POS_ONE)) ? POS_BITS'(POS_ONE) : point_pos;
    wr_point.col[0] = point_red;
    wr_point.col[1] = point_green;
    wr_point.col[2] = point_blue;
    wr_point.col[3] = point_alpha;
  end

  frci_ram #(
    .WIDTH(POINT_BITS),
    .DEPTH(MAX_POINTS)
  ) u_points (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (wr_point),
    .raddr (rd_addr),
    .rdata (rd_point)
  );

  frci_div_step u_div (
    .rem      (rem),
    .den      (den),
    .rem_next (rem_next),
    .qbit     (qbit)
  );

  frci_lerp #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_lerp (
    .clk   (clk),
    .frac  (frac),
    .c0    (c0[k]),
    .c1    (c1[k]),
    .color (lerp_color)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (lookup_fire) begin
          if (few_points) begin
            state_next = S_OUT;
          end else if (pos_sat) begin
            state_next = S_SRD;
          end else begin
            state_next = S_DIVP;
          end
        end
      end
      S_DIVP: begin
        if (cnt == CW'(1)) begin
          state_next = S_SRD;
        end
      end
      S_SRD:  state_next = S_SCMP;
      S_SCMP: state_next = search_more ? S_SRD : S_LRD;
      S_LRD:  state_next = S_LCAP;
      S_LCAP: state_next = (frac_zero || frac_full) ? S_MUL : S_DIVF;
      S_DIVF: begin
        if (cnt == CW'(1)) begin
          state_next = S_MUL;
        end
      end
      S_MUL:  state_next = S_ACC;
      S_ACC:  state_next = (k == 2'd3) ? S_OUT : S_MUL;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_tready = 1'b0;
    rd_addr  = idx;
    case (state)
      S_IDLE:  s_tready = 1'b1;
      S_SRD:   rd_addr  = idx_up;
      S_LRD:   rd_addr  = idx;
      default: rd_addr  = idx;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      num_points      <= NUM_POINTS_RESET;
      feed_full_scale <= FEED_FULL_SCALE_RESET;
      m_tvalid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NUM_POINTS:      num_points      <= NUM_POINTS_BITS'(cfg_data);
          REG_FEED_FULL_SCALE: feed_full_scale <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        idx       <= '0;
        k         <= '0;
        res_nomap <= few_points;
        res_col   <= '0;
        pos       <= POS_BITS'(POS_ONE);
        rem       <= feed_rate;
        den       <= feed_full_scale;
        cnt       <= CW'(POS_DIV_STEPS);
      end
      S_DIVP: begin
        rem <= rem_next;
        quo <= {quo[QW-2:0], qbit};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          pos <= POS_BITS'({quo[POS_DIV_STEPS-2:0], qbit});
        end
      end
      S_SCMP: begin
        p1 <= rd_point.pos;
        c1 <= rd_point.col;
        if (search_more) begin
          idx <= idx_up;
        end
      end
      S_LCAP: begin
        c0  <= rd_point.col;
        rem <= num_f;
        den <= den_f;
        cnt <= CW'(FRACTION_BITS);
        if (frac_zero) begin
          frac <= '0;
        end else if (frac_full) begin
          frac <= (FRACTION_BITS + 1)'(1) << FRACTION_BITS;
        end
      end
      S_DIVF: begin
        rem <= rem_next;
        quo <= {quo[QW-2:0], qbit};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          frac <= (FRACTION_BITS + 1)'({quo[FRACTION_BITS-2:0], qbit});
        end
      end
      S_ACC: begin
        res_col[k] <= lerp_color;
        k          <= k + 2'd1;
      end
      S_OUT: begin
        if (out_free) begin
          out_col   <= res_col;
          out_seg   <= SEG_BITS'(idx);
          out_nomap <= res_nomap;
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = {4'b0000, out_seg, out_col[3], out_col[2], out_col[1], out_col[0]};
  assign m_tuser = out_nomap;

endmodule
